FILE: rtl/core/pws_pkg.sv
// ----------------------------------------------------------------------------
// pws_pkg
// shared types and constants of the polar waypoint steering core
// ----------------------------------------------------------------------------
package pws_pkg;

  localparam int ANGLE_STEPS = 24;
  localparam int XY_W        = 28;  // cordic datapath width, covers gain growth

  localparam logic [3:0] REG_GOAL_X   = 4'd0;
  localparam logic [3:0] REG_GOAL_Y   = 4'd1;
  localparam logic [3:0] REG_DIST_G   = 4'd2;
  localparam logic [3:0] REG_HEAD_G   = 4'd3;
  localparam logic [3:0] REG_ARRIVE   = 4'd4;
  localparam logic [3:0] REG_SPEED    = 4'd5;
  localparam logic [3:0] REG_TURN     = 4'd6;

  localparam logic [16:0] INV_GAIN_Q16 = 17'd39797;
  localparam logic [31:0] TWO_PI_Q29   = 32'd3373259426;
  localparam logic [15:0] CRAWL_SPEED  = 16'd102;
  localparam logic [31:0] QUARTER_TURN = 32'h4000_0000;
  localparam logic [31:0] HALF_TURN    = 32'h8000_0000;

  typedef struct packed {
    logic signed [15:0] goal_x;
    logic signed [15:0] goal_y;
    logic [15:0]        dist_gain;
    logic [15:0]        head_gain;
    logic [15:0]        arrive_tol;
    logic [15:0]        speed_lim;
    logic [15:0]        turn_lim;
  } cfg_t;

  typedef struct packed {
    logic signed [XY_W-1:0] x;
    logic signed [XY_W-1:0] y;
    logic [31:0]            z;
    logic [15:0]            heading;
  } cordic_t;

  function automatic logic [31:0] atan_lut(input int i);
    logic [31:0] t;
    case (i)
      0: t = 32'h20000000;  1: t = 32'h12E4051E;  2: t = 32'h09FB385B;
      3: t = 32'h051111D4;  4: t = 32'h028B0D43;  5: t = 32'h0145D7E1;
      6: t = 32'h00A2F61E;  7: t = 32'h00517C55;  8: t = 32'h0028BE53;
      9: t = 32'h00145F2F; 10: t = 32'h000A2F98; 11: t = 32'h000517CC;
      12: t = 32'h00028BE6; 13: t = 32'h000145F3; 14: t = 32'h0000A2FA;
      15: t = 32'h0000517D; 16: t = 32'h000028BE; 17: t = 32'h0000145F;
      18: t = 32'h00000A30; 19: t = 32'h00000518; 20: t = 32'h0000028C;
      21: t = 32'h00000146; 22: t = 32'h000000A3; default: t = 32'h00000051;
    endcase
    return t;
  endfunction

endpackage

FILE: rtl/core/pws_cordic_stage.sv
// ----------------------------------------------------------------------------
// pws_cordic_stage
// one registered cordic vectoring micro-rotation with stall support
// ----------------------------------------------------------------------------
module pws_cordic_stage #(
  parameter int SHIFT = 0
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            en,
  input  logic            in_vld,
  input  pws_pkg::cordic_t in_d,
  output logic            out_vld,
  output pws_pkg::cordic_t out_d
);
  import pws_pkg::*;

  logic             vld_r;
  cordic_t          d_r, d_nxt;
  logic signed [XY_W-1:0] xs, ys;

  always_comb begin
    xs = in_d.x >>> SHIFT;
    ys = in_d.y >>> SHIFT;
    d_nxt = in_d;
    if (!in_d.y[XY_W-1]) begin
      d_nxt.x = in_d.x + ys;
      d_nxt.y = in_d.y - xs;
      d_nxt.z = in_d.z + atan_lut(SHIFT);
    end else begin
      d_nxt.x = in_d.x - ys;
      d_nxt.y = in_d.y + xs;
      d_nxt.z = in_d.z - atan_lut(SHIFT);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_r <= d_nxt;
    end
  end

  assign out_vld = vld_r;
  assign out_d   = d_r;
endmodule

FILE: rtl/core/pws_cfg_regs.sv
// ----------------------------------------------------------------------------
// pws_cfg_regs
// configuration register file
// ----------------------------------------------------------------------------
module pws_cfg_regs (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          cfg_valid,
  input  logic [3:0]    cfg_index,
  input  logic [15:0]   cfg_data,
  output logic          cfg_ready,
  output pws_pkg::cfg_t cfg
);
  import pws_pkg::*;

  cfg_t cfg_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.goal_x     <= '0;
      cfg_r.goal_y     <= '0;
      cfg_r.dist_gain  <= 16'd3277;
      cfg_r.head_gain  <= 16'd8192;
      cfg_r.arrive_tol <= 16'd51;
      cfg_r.speed_lim  <= 16'd1229;
      cfg_r.turn_lim   <= 16'd3072;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_GOAL_X: cfg_r.goal_x     <= cfg_data;
        REG_GOAL_Y: cfg_r.goal_y     <= cfg_data;
        REG_DIST_G: cfg_r.dist_gain  <= cfg_data;
        REG_HEAD_G: cfg_r.head_gain  <= cfg_data;
        REG_ARRIVE: cfg_r.arrive_tol <= cfg_data;
        REG_SPEED:  cfg_r.speed_lim  <= cfg_data;
        REG_TURN:   cfg_r.turn_lim   <= cfg_data;
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;
endmodule

FILE: rtl/core/polar_waypoint_steering_core.sv
// ----------------------------------------------------------------------------
// polar_waypoint_steering_core
// proportional steering toward a configured waypoint
// ----------------------------------------------------------------------------
// in_tdata carries one pose word (pos_x, pos_y, heading); out_tdata carries
// the command word (linear_speed, turn_rate) and out_tuser the goal flag.
// cfg_valid/cfg_index/cfg_data write the seven registers; cfg_ready is always
// high; the user must make writes only while no word is in flight, unguarded.
// with N = min(CORDIC_STAGES, 24) the pipeline is N + 6 register stages deep
// and takes one word a cycle while the output is not stalled.
// stages: delta and pre-rotation, one stage per cordic micro-rotation,
// then distance multiply with angle error, rho with angle scale, alpha
// rounding with arrival compare, gain multiplies, saturation into the
// output register.
// the whole pipe moves together; when out_tready is low and the output
// register holds a word, every stage holds and in_tready drops, so
// nothing is lost or repeated; empty stages hold as well.
// reset clears all valid bits and loads the register defaults.
// ----------------------------------------------------------------------------
module polar_waypoint_steering_core #(
  parameter int CORDIC_STAGES = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,   // pos_x[15:0], pos_y[31:16], heading[47:32]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // linear_speed[15:0], turn_rate[32:16], zero
  output logic        out_tuser,  // goal_reached
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [3:0]  cfg_index,
  input  logic [15:0] cfg_data
);
  import pws_pkg::*;

  localparam int NST = (CORDIC_STAGES > ANGLE_STEPS) ? ANGLE_STEPS : CORDIC_STAGES;

  cfg_t cfg;
  logic en;
  logic out_vld_r;

  pws_cfg_regs u_cfg (
    .clk, .rst_n, .cfg_valid, .cfg_index, .cfg_data, .cfg_ready, .cfg
  );

  assign en        = !out_vld_r || out_tready;
  assign in_tready = en;

  // stage 0: delta and quarter-turn pre-rotation
  logic signed [16:0] dx, dy;
  cordic_t p_nxt;
  logic    [NST:0] cv;
  cordic_t cd [NST+1];

  always_comb begin
    dx = 17'(cfg.goal_x) - 17'(signed'(in_tdata[15:0]));
    dy = 17'(cfg.goal_y) - 17'(signed'(in_tdata[31:16]));
    p_nxt.heading = in_tdata[47:32];
    p_nxt.x = {{(XY_W-25){dx[16]}}, dx, 8'd0};
    p_nxt.y = {{(XY_W-25){dy[16]}}, dy, 8'd0};
    p_nxt.z = '0;
    if (dx[16]) begin
      if (!dy[16]) begin
        p_nxt.x = {{(XY_W-25){dy[16]}}, dy, 8'd0};
        p_nxt.y = -{{(XY_W-25){dx[16]}}, dx, 8'd0};
        p_nxt.z = QUARTER_TURN;
      end else begin
        p_nxt.x = -{{(XY_W-25){dy[16]}}, dy, 8'd0};
        p_nxt.y = {{(XY_W-25){dx[16]}}, dx, 8'd0};
        p_nxt.z = 32'd0 - QUARTER_TURN;
      end
    end
  end

  logic    pre_vld_r;
  cordic_t pre_r;
  always_ff @(posedge clk) begin
    if (!rst_n) pre_vld_r <= 1'b0;
    else if (en) pre_vld_r <= in_tvalid;
  end
  always_ff @(posedge clk) begin
    if (en) pre_r <= p_nxt;
  end

  assign cv[0] = pre_vld_r;
  assign cd[0] = pre_r;

  for (genvar g = 0; g < NST; g++) begin : g_cordic
    pws_cordic_stage #(.SHIFT(g)) u_stage (
      .clk, .rst_n, .en,
      .in_vld(cv[g]), .in_d(cd[g]),
      .out_vld(cv[g+1]), .out_d(cd[g+1])
    );
  end

  // stage a: distance product, angle error
  cordic_t    fin;
  logic [26:0] mag;
  logic [31:0] a_err;
  logic        a_vld_r, a_neg_r;
  logic [43:0] a_prod_r;
  logic [31:0] a_mag_r;
  assign fin   = cd[NST];
  assign mag   = (fin.x > 0) ? fin.x[26:0] : 27'd0;
  assign a_err = fin.z - {fin.heading, 16'd0};

  always_ff @(posedge clk) begin
    if (!rst_n) a_vld_r <= 1'b0;
    else if (en) a_vld_r <= cv[NST];
  end
  always_ff @(posedge clk) begin
    if (en) begin
      a_prod_r <= 44'(mag) * 44'(INV_GAIN_Q16);
      a_neg_r  <= a_err > HALF_TURN;
      a_mag_r  <= (a_err > HALF_TURN) ? (32'd0 - a_err) : a_err;
    end
  end

  // stage b: rho, angle scaling to q20
  logic        b_vld_r, b_neg_r, b_far_r;
  logic [19:0] b_rho_r;
  logic [63:0] b_aprod_r;
  always_ff @(posedge clk) begin
    if (!rst_n) b_vld_r <= 1'b0;
    else if (en) b_vld_r <= a_vld_r;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      b_rho_r   <= 20'((a_prod_r + 44'(1 << 23)) >> 24);
      b_aprod_r <= 64'(a_mag_r) * 64'(TWO_PI_Q29);
      b_neg_r   <= a_neg_r;
      b_far_r   <= a_mag_r > QUARTER_TURN;
    end
  end

  // stage c: alpha in q20, arrival compare
  logic        c_vld_r, c_neg_r, c_far_r, c_arr_r;
  logic [19:0] c_rho_r;
  logic [21:0] c_alpha_r;
  always_ff @(posedge clk) begin
    if (!rst_n) c_vld_r <= 1'b0;
    else if (en) c_vld_r <= b_vld_r;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      c_alpha_r <= 22'((b_aprod_r + 64'(64'd1 << 40)) >> 41);
      c_rho_r   <= b_rho_r;
      c_neg_r   <= b_neg_r;
      c_far_r   <= b_far_r;
      c_arr_r   <= b_rho_r <= 20'(cfg.arrive_tol);
    end
  end

  // stage d: gain multiplies
  logic        d_vld_r, d_neg_r, d_far_r, d_arr_r;
  logic [37:0] d_w_r;
  logic [35:0] d_v_r;
  always_ff @(posedge clk) begin
    if (!rst_n) d_vld_r <= 1'b0;
    else if (en) d_vld_r <= c_vld_r;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      d_w_r   <= 38'(cfg.head_gain) * 38'(c_alpha_r);
      d_v_r   <= 36'(cfg.dist_gain) * 36'(c_rho_r);
      d_neg_r <= c_neg_r;
      d_far_r <= c_far_r;
      d_arr_r <= c_arr_r;
    end
  end

  // stage e: rounding, crawl, saturation into the output word
  logic [37:0] w_rnd, v_rnd;
  logic [16:0] w_sat, w_out;
  logic [15:0] v_sat;
  logic [15:0] out_v_r;
  logic [16:0] out_w_r;
  logic        out_goal_r;

  always_comb begin
    w_rnd = (d_w_r + 38'(1 << 21)) >> 22;
    v_rnd = d_far_r ? 38'(CRAWL_SPEED) : 38'((d_v_r + 36'(1 << 11)) >> 12);
    w_sat = (w_rnd > 38'(cfg.turn_lim)) ? 17'(cfg.turn_lim) : w_rnd[16:0];
    v_sat = (v_rnd > 38'(cfg.speed_lim)) ? cfg.speed_lim : v_rnd[15:0];
    w_out = d_neg_r ? (17'd0 - w_sat) : w_sat;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_vld_r <= 1'b0;
    else if (en) out_vld_r <= d_vld_r;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      out_v_r    <= d_arr_r ? 16'd0 : v_sat;
      out_w_r    <= d_arr_r ? 17'd0 : w_out;
      out_goal_r <= d_arr_r;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {7'd0, out_w_r, out_v_r};
  assign out_tuser  = out_goal_r;
endmodule

FILE: rtl/core/pws_checker.sv
// ----------------------------------------------------------------------------
// pws_port_checker
// port-level checks of the steering core
// ----------------------------------------------------------------------------
module pws_port_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [39:0] out_tdata,
  input logic        out_tuser
);
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("output word changed under stall");
  a_goal_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tdata == 40'd0)
    else $error("goal word not zero");
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready == (!out_tvalid || out_tready))
    else $error("input ready not tied to output drain");
endmodule

bind polar_waypoint_steering_core pws_port_checker u_pws_port_checker (
  .clk, .rst_n, .in_tready, .out_tvalid, .out_tready, .out_tdata, .out_tuser
);
